[src/rcdc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rcdc_pkg
// Shared types, constants and the cumulative month table of the calendar
// day-count codec.
// ----------------------------------------------------------------------------
package rcdc_pkg;

    localparam int BASE_YEAR_DEFAULT = 1988;

    // Reciprocal constants for division by 100 (12-bit operands) and by 365
    // (operands up to 32768, one correction step afterwards).
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [15:0] DIV365_MUL   = 16'd45965;
    localparam int          DIV365_SHIFT = 24;

    localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

    typedef enum logic {
        OP_ENCODE = 1'b0,
        OP_DECODE = 1'b1
    } op_t;

    typedef struct packed {
        op_t         operation;
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [31:0] packed_in;
    } in_t;

    typedef struct packed {
        logic [31:0] packed_out;
        logic [11:0] year_out;
        logic [3:0]  month_out;
        logic [4:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
    } out_t;

    // After the first stage: encode prep and the raw day/365 estimate.
    typedef struct packed {
        op_t         op;
        logic [11:0] ye;
        logic [14:0] part_days;
        logic [15:0] dcount;
        logic [6:0]  qa;
        logic [16:0] hms;
    } split_t;

    // After the second stage: the year to count leap days for.
    typedef struct packed {
        op_t         op;
        logic [11:0] y0;
        logic [14:0] part_days;
        logic [8:0]  rem;
        logic [16:0] hms;
    } year_t;

    // Leap days since the base year at y0, y0 - 1 and y0 - 2.
    typedef struct packed {
        op_t         op;
        logic [11:0] y0;
        logic [14:0] part_days;
        logic [8:0]  rem;
        logic [16:0] hms;
        logic [15:0] l0;
        logic [15:0] l1;
        logic [15:0] l2;
    } leap_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] word;
        logic [11:0] year;
        logic [9:0]  doy;
        logic        leap;
        logic [16:0] hms;
    } doy_t;

    // Days before the first of a month; months outside 1..12 give zero.
    function automatic logic [8:0] days_before(input logic leap, input logic [3:0] month);
        logic [8:0] d;
        case (month)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        if (leap && month >= 4'd3 && month <= 4'd12)
        begin
            d = d + 9'd1;
        end
        return d;
    endfunction

endpackage
`default_nettype wire

[src/rcdc_year_split.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rcdc_year_split
// Stages one and two: clamp the month and build the partial day count for
// encode; split the day number into whole years and a remainder for decode.
// ----------------------------------------------------------------------------
module rcdc_year_split #(
    parameter int BASE_YEAR = rcdc_pkg::BASE_YEAR_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic [1:0]    ld,
    input  wire rcdc_pkg::in_t req,
    output rcdc_pkg::year_t    yr
);

    rcdc_pkg::split_t s1_next;
    rcdc_pkg::split_t s1_reg;
    rcdc_pkg::year_t  s2_next;
    rcdc_pkg::year_t  s2_reg;

    logic [3:0]  month_c;
    logic [31:0] prod;
    logic [15:0] qmul;
    logic signed [16:0] r;
    logic [6:0]  q;

    always_comb
    begin
        month_c = req.month;
        if (req.month == 4'd0)
        begin
            month_c = 4'd1;
        end
        else if (req.month > 4'd12)
        begin
            month_c = 4'd12;
        end

        s1_next.op = req.operation;
        // January and February count leap days through the previous year
        if (month_c < 4'd3)
        begin
            s1_next.ye = (req.year == 12'd0) ? 12'd0 : req.year - 12'd1;
        end
        else
        begin
            s1_next.ye = req.year;
        end
        s1_next.part_days = 15'(({3'b000, req.year} - 15'(BASE_YEAR)) * 15'd365)
                          + {6'b0, rcdc_pkg::days_before(1'b0, month_c)}
                          + {10'b0, req.day} - 15'd1;
        s1_next.dcount = {1'b0, req.packed_in[31:17]} + 16'd1;
        prod = {16'b0, s1_next.dcount} * {16'b0, rcdc_pkg::DIV365_MUL};
        s1_next.qa = prod[rcdc_pkg::DIV365_SHIFT+6:rcdc_pkg::DIV365_SHIFT];
        if (req.operation == rcdc_pkg::OP_DECODE)
        begin
            s1_next.hms = req.packed_in[16:0];
        end
        else
        begin
            s1_next.hms = {req.hour, req.minute, req.second};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            s1_reg <= s1_next;
        end
    end

    // The reciprocal estimate is exact or one too high; correct once.
    always_comb
    begin
        qmul = 16'(s1_reg.qa) * 16'(rcdc_pkg::DAYS_PER_YEAR);
        r = signed'({1'b0, s1_reg.dcount}) - signed'({1'b0, qmul});
        q = s1_reg.qa;
        s2_next.rem = r[8:0];
        if (r[16])
        begin
            q = s1_reg.qa - 7'd1;
            s2_next.rem = r[8:0] + rcdc_pkg::DAYS_PER_YEAR;
        end
        s2_next.op = s1_reg.op;
        s2_next.part_days = s1_reg.part_days;
        s2_next.hms = s1_reg.hms;
        if (s1_reg.op == rcdc_pkg::OP_DECODE)
        begin
            s2_next.y0 = {5'b0, q} + 12'(BASE_YEAR);
        end
        else
        begin
            s2_next.y0 = s1_reg.ye;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            s2_reg <= s2_next;
        end
    end

    assign yr = s2_reg;

endmodule
`default_nettype wire

[src/rcdc_leap_count.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rcdc_leap_count
// Stages three and four: leap days since the base year, then the final
// encode word or the decoded year, day of year and leap flag.
// ----------------------------------------------------------------------------
module rcdc_leap_count #(
    parameter int BASE_YEAR = rcdc_pkg::BASE_YEAR_DEFAULT
) (
    input  wire logic            clk,
    input  wire logic [1:0]      ld,
    input  wire rcdc_pkg::year_t yr,
    output rcdc_pkg::doy_t       dy
);

    localparam int BASE_PREV = BASE_YEAR - 1;
    localparam int LT_BASE   = BASE_PREV / 4 - BASE_PREV / 100 + BASE_PREV / 400;

    rcdc_pkg::leap_t s3_next;
    rcdc_pkg::leap_t s3_reg;
    rcdc_pkg::doy_t  s4_next;
    rcdc_pkg::doy_t  s4_reg;

    logic [14:0] days;
    logic [15:0] rem_w;

    // y/4 - y/100 + y/400, offset by the count through the year before base
    function automatic logic [15:0] leaps_since(input logic [11:0] y);
        logic [9:0]  q4;
        logic [24:0] p100;
        logic [22:0] p400;
        q4   = y[11:2];
        p100 = {13'b0, y} * {12'b0, rcdc_pkg::DIV100_MUL};
        p400 = {13'b0, q4} * {10'b0, rcdc_pkg::DIV100_MUL};
        return 16'(q4) - 16'(p100[24:rcdc_pkg::DIV100_SHIFT])
             + 16'(p400[22:rcdc_pkg::DIV100_SHIFT]) - 16'(LT_BASE);
    endfunction

    always_comb
    begin
        s3_next.op = yr.op;
        s3_next.y0 = yr.y0;
        s3_next.part_days = yr.part_days;
        s3_next.rem = yr.rem;
        s3_next.hms = yr.hms;
        s3_next.l0 = leaps_since(yr.y0);
        s3_next.l1 = leaps_since(yr.y0 - 12'd1);
        s3_next.l2 = leaps_since(yr.y0 - 12'd2);
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            s3_reg <= s3_next;
        end
    end

    always_comb
    begin
        days = s3_reg.part_days + s3_reg.l0[14:0];
        rem_w = {7'b0, s3_reg.rem};
        s4_next.op = s3_reg.op;
        s4_next.hms = s3_reg.hms;
        s4_next.word = {days, s3_reg.hms};
        // Remainder inside this year's leap slack: step back one year
        if (rem_w > s3_reg.l1)
        begin
            s4_next.year = s3_reg.y0;
            s4_next.doy = 10'(rem_w - s3_reg.l1);
            s4_next.leap = (s3_reg.l0 != s3_reg.l1);
        end
        else
        begin
            s4_next.year = s3_reg.y0 - 12'd1;
            s4_next.doy = 10'(rem_w + 16'(rcdc_pkg::DAYS_PER_YEAR) - s3_reg.l2);
            s4_next.leap = (s3_reg.l1 != s3_reg.l2);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            s4_reg <= s4_next;
        end
    end

    assign dy = s4_reg;

endmodule
`default_nettype wire

[src/rcdc_month_find.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rcdc_month_find
// Stage five: find the month from the day of year and form the result.
// ----------------------------------------------------------------------------
module rcdc_month_find (
    input  wire logic           clk,
    input  wire logic           ld,
    input  wire rcdc_pkg::doy_t dy,
    output rcdc_pkg::out_t      rsp
);

    rcdc_pkg::out_t out_next;
    rcdc_pkg::out_t out_reg;

    logic [3:0] m;

    always_comb
    begin
        // December takes whatever is left after November
        m = 4'd12;
        for (int k = 11; k >= 1; k--)
        begin
            if (dy.doy <= {1'b0, rcdc_pkg::days_before(dy.leap, 4'(k + 1))})
            begin
                m = 4'(k);
            end
        end

        out_next = '0;
        if (dy.op == rcdc_pkg::OP_DECODE)
        begin
            out_next.year_out = dy.year;
            out_next.month_out = m;
            out_next.day_out = 5'(dy.doy - {1'b0, rcdc_pkg::days_before(dy.leap, m)});
            out_next.hour_out = dy.hms[16:12];
            out_next.minute_out = dy.hms[11:6];
            out_next.second_out = dy.hms[5:0];
        end
        else
        begin
            out_next.packed_out = dy.word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp = out_reg;

endmodule
`default_nettype wire

[src/rtc_calendar_day_count_codec.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rtc_calendar_day_count_codec
// Converts a Gregorian date and time to a packed clock word and back.
// ----------------------------------------------------------------------------
// Requests enter on req_valid/req_ready with a req struct; operation selects
// encode (date fields to word) or decode (packed_in to date fields).
// Results leave on rsp_valid/rsp_ready with a rsp struct, one per request,
// in request order. Fields not produced by the operation read as zero.
// A new request is taken every cycle unless the pipeline is full behind a
// stalled receiver. The five register stages are: month clamp and the
// day/365 estimate, the remainder correction, three leap-day counts, the
// year and day-of-year pick, and the month search into the output register.
// Each stage holds a valid bit; a stage loads whenever it is empty or the
// stage after it moves, so bubbles close up while the receiver stalls.
// With rsp_ready low the result holds, and up to four more requests are
// still taken before req_ready drops.
// Reset clears all valid bits; no clearing pass is needed, and a request
// can be taken as soon as reset is released.
// ----------------------------------------------------------------------------
module rtc_calendar_day_count_codec #(
    parameter int BASE_YEAR = rcdc_pkg::BASE_YEAR_DEFAULT
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire rcdc_pkg::in_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output rcdc_pkg::out_t     rsp
);

    localparam int STAGES = 5;

    logic [STAGES-1:0] v_reg;
    logic [STAGES-1:0] v_next;
    logic [STAGES-1:0] en;
    logic              in_acc;
    logic              out_acc;

    rcdc_pkg::year_t yr;
    rcdc_pkg::doy_t  dy;

    always_comb
    begin
        en[STAGES-1] = !v_reg[STAGES-1] || rsp_ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next = {v_reg[STAGES-2:0], req_valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < STAGES; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    assign req_ready = en[0];
    assign rsp_valid = v_reg[STAGES-1];
    assign in_acc    = req_valid && req_ready;
    assign out_acc   = rsp_valid && rsp_ready;

    rcdc_year_split #(
        .BASE_YEAR(BASE_YEAR)
    ) u_year_split (
        .clk(clk),
        .ld (en[1:0]),
        .req(req),
        .yr (yr)
    );

    rcdc_leap_count #(
        .BASE_YEAR(BASE_YEAR)
    ) u_leap_count (
        .clk(clk),
        .ld (en[3:2]),
        .yr (yr),
        .dy (dy)
    );

    rcdc_month_find u_month_find (
        .clk(clk),
        .ld (en[4]),
        .dy (dy),
        .rsp(rsp)
    );

    // A full pipeline with a stalled receiver must not take a transaction
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (&v_reg && !rsp_ready) |-> !req_ready)
        else $error("request taken while pipeline full and stalled");

    // Items in flight change only by transactions on the two channels
    a_count_kept: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ($countones(v_reg) == $past($countones(v_reg))
                          + int'($past(in_acc)) - int'($past(out_acc))))
        else $error("item lost or repeated in pipeline");

    // Decode results carry a month 1..12 and a nonzero year, encode none
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.month_out <= 4'd12
                       && ((rsp.month_out == 4'd0) == (rsp.year_out == 12'd0))))
        else $error("decoded month or year out of range");

    // A decode result never carries a packed word
    a_decode_word: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.month_out != 4'd0) |-> (rsp.packed_out == 32'd0))
        else $error("decode result with nonzero packed word");

endmodule
`default_nettype wire
